[rtl/assert_macros.svh]
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and synchronous active-high reset.
`define MFB_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Same, on the module's own clk and rst.
`define MFB_ASSERT(lbl, prop, msg) \
  `MFB_ASSERT_CLK(lbl, clk, rst, prop, msg)

`endif

[rtl/mfb_pkg.sv]
// Shared types and constants of the mono frame buffer.
package mfb_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 152;
  localparam int DISPLAY_HEIGHT_DEF = 152;

  typedef enum logic [1:0] {
    ACT_PLOT  = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_FLUSH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  // Panel command set
  localparam logic [7:0] CMD_WIN_X     = 8'h44;
  localparam logic [7:0] CMD_WIN_Y     = 8'h45;
  localparam logic [7:0] CMD_CUR_X     = 8'h4E;
  localparam logic [7:0] CMD_CUR_Y     = 8'h4F;
  localparam logic [7:0] CMD_WRITE_RAM = 8'h24;
  localparam logic [7:0] CMD_UPD_CTRL  = 8'h22;
  localparam logic [7:0] UPD_SEQ_FULL  = 8'hC4;
  localparam logic [7:0] CMD_ACTIVATE  = 8'h20;
  localparam logic [7:0] CMD_NOP       = 8'hFF;

  localparam logic [7:0] PIX_MSB   = 8'h80;
  localparam logic [7:0] PIX_WHITE = 8'hFF;

  // One byte offered by the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       cmd;
    logic       last;
  } emit_t;

endpackage

[rtl/mfb_req_if.sv]
// Request channel: drawing, load and flush requests.
interface mfb_req_if;
  import mfb_pkg::*;

  logic          valid;
  logic          ready;
  action_t       action;
  logic [9:0]    pixel_x;
  logic [9:0]    pixel_y;
  logic [9:0]    rect_width;
  logic [9:0]    rect_height;
  logic          pixel_color;
  logic [7:0]    image_byte;
  logic [11:0]   image_offset;
  logic [9:0]    flush_row;

  modport source (
    output valid, action, pixel_x, pixel_y, rect_width, rect_height,
           pixel_color, image_byte, image_offset, flush_row,
    input  ready
  );

  modport sink (
    input  valid, action, pixel_x, pixel_y, rect_width, rect_height,
           pixel_color, image_byte, image_offset, flush_row,
    output ready
  );
endinterface

[rtl/mfb_res_if.sv]
// Result channel: panel byte stream.
interface mfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] panel_byte;
  logic       is_command;
  logic       last_byte;

  modport source (
    output valid, panel_byte, is_command, last_byte,
    input  ready
  );

  modport sink (
    input  valid, panel_byte, is_command, last_byte,
    output ready
  );
endinterface

[rtl/mfb_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module mfb_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mfb_ctrl.sv]
// Frame store sequencer: clearing pass, pixel read-modify-write, fill walk,
// image load and row flush.
`include "assert_macros.svh"

module mfb_ctrl #(
  parameter  int DISPLAY_WIDTH  = mfb_pkg::DISPLAY_WIDTH_DEF,
  parameter  int DISPLAY_HEIGHT = mfb_pkg::DISPLAY_HEIGHT_DEF,
  localparam int RowBytes       = (DISPLAY_WIDTH + 7) / 8,
  localparam int StoreSize      = RowBytes * DISPLAY_HEIGHT,
  localparam int AddrW          = (StoreSize > 1) ? $clog2(StoreSize) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  mfb_pkg::rot_t       rotation,
  mfb_req_if.sink             req,
  output mfb_pkg::emit_t      emit,
  input  logic                emit_ready,
  output logic                ram_we,
  output logic [AddrW-1:0]    ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic                ram_re,
  output logic [AddrW-1:0]    ram_raddr,
  input  logic [7:0]          ram_rdata
);
  import mfb_pkg::*;

  localparam int DcW = (RowBytes > 1) ? $clog2(RowBytes) : 1;
  localparam logic [10:0]      WidthC     = 11'(DISPLAY_WIDTH);
  localparam logic [10:0]      HeightC    = 11'(DISPLAY_HEIGHT);
  localparam logic [15:0]      StoreSizeC = 16'(StoreSize);
  localparam logic [AddrW-1:0] ClrLast    = AddrW'(StoreSize - 1);
  localparam logic [DcW-1:0]   DcLast     = DcW'(RowBytes - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PIX, ST_RD, ST_WR, ST_HDR, ST_CUR, ST_DRD, ST_DOUT, ST_TRL
  } state_t;

  state_t           state;
  logic [AddrW-1:0] clr_addr;
  logic [9:0]       cur_i;
  logic [9:0]       cur_j;
  logic [9:0]       x0;
  logic [10:0]      xe;
  logic [10:0]      ye;
  logic             color;
  logic [7:0]       px;
  logic [9:0]       py;
  logic [AddrW-1:0] wr_addr;
  logic [9:0]       row;
  logic [AddrW-1:0] row_base;
  logic             last_row;
  logic [2:0]       idx;
  logic [DcW-1:0]   dcnt;

  logic        rot_ok;
  logic [7:0]  rot_px;
  logic [9:0]  rot_py;
  logic        base_ok;
  logic        cross_ok;
  logic [10:0] px_w;
  logic [10:0] py_w;
  logic        step_i;
  logic        step_j;
  logic [10:0] sum_x;
  logic [10:0] sum_y;
  logic [10:0] fill_xe;
  logic [10:0] fill_ye;
  logic        fill_ok;
  logic        row_ok;
  logic        load_hit;
  logic [AddrW-1:0] pix_addr;
  logic [7:0]  mask;
  logic        emit_take;

  assign req.ready = (state == ST_IDLE);

  // Rotation and clipping of the current point
  always_comb begin
    base_ok  = ({1'b0, cur_i} < WidthC) && ({1'b0, cur_j} < HeightC);
    cross_ok = ({1'b0, cur_j} < WidthC) && ({1'b0, cur_i} < HeightC);
    px_w     = {1'b0, cur_i};
    py_w     = {1'b0, cur_j};
    rot_ok   = base_ok;
    unique case (rotation)
      ROT_0: begin
        px_w = {1'b0, cur_i};
        py_w = {1'b0, cur_j};
      end
      ROT_90: begin
        px_w   = WidthC - 11'd1 - {1'b0, cur_j};
        py_w   = {1'b0, cur_i};
        rot_ok = base_ok && cross_ok;
      end
      ROT_180: begin
        px_w = WidthC - 11'd1 - {1'b0, cur_i};
        py_w = HeightC - 11'd1 - {1'b0, cur_j};
      end
      ROT_270: begin
        px_w   = {1'b0, cur_j};
        py_w   = HeightC - 11'd1 - {1'b0, cur_i};
        rot_ok = base_ok && cross_ok;
      end
    endcase
    rot_px = px_w[7:0];
    rot_py = py_w[9:0];
  end

  assign step_i = ({1'b0, cur_i} + 11'd1) < xe;
  assign step_j = ({1'b0, cur_j} + 11'd1) < ye;

  // Rectangle clip at request time
  always_comb begin
    sum_x   = {1'b0, req.pixel_x} + {1'b0, req.rect_width};
    sum_y   = {1'b0, req.pixel_y} + {1'b0, req.rect_height};
    fill_xe = (sum_x > WidthC) ? WidthC : sum_x;
    fill_ye = (sum_y > HeightC) ? HeightC : sum_y;
    fill_ok = ({1'b0, req.pixel_x} < fill_xe) && ({1'b0, req.pixel_y} < fill_ye);
  end

  assign row_ok   = {1'b0, req.flush_row} < HeightC;
  assign load_hit = (state == ST_IDLE) && req.valid && (req.action == ACT_LOAD) &&
                    ({4'b0, req.image_offset} < StoreSizeC);

  assign pix_addr = AddrW'(px >> 3) + AddrW'(py * RowBytes);
  assign mask     = PIX_MSB >> px[2:0];

  // Store ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = color ? (ram_rdata | mask) : (ram_rdata & ~mask);
    ram_re    = 1'b0;
    ram_raddr = pix_addr;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = PIX_WHITE;
      end
      ST_IDLE: begin
        ram_we    = load_hit;
        ram_waddr = AddrW'(req.image_offset);
        ram_wdata = req.image_byte;
      end
      ST_RD: ram_re = 1'b1;
      ST_WR: ram_we = 1'b1;
      ST_DRD: begin
        ram_re    = 1'b1;
        ram_raddr = row_base + AddrW'(dcnt);
      end
      default: ;
    endcase
  end

  // Flush byte stream
  always_comb begin
    emit = '{valid: 1'b0, data: 8'h00, cmd: 1'b0, last: 1'b0};
    case (state)
      ST_HDR: begin
        emit.valid = 1'b1;
        case (idx)
          3'd0: begin emit.data = CMD_WIN_X; emit.cmd = 1'b1; end
          3'd2: emit.data = 8'(DISPLAY_WIDTH >> 3);
          3'd3: begin emit.data = CMD_WIN_Y; emit.cmd = 1'b1; end
          3'd6: emit.data = 8'(DISPLAY_HEIGHT);
          3'd7: emit.data = 8'(DISPLAY_HEIGHT >> 8);
          default: emit.data = 8'h00;
        endcase
      end
      ST_CUR: begin
        emit.valid = 1'b1;
        case (idx)
          3'd0: begin emit.data = CMD_CUR_X; emit.cmd = 1'b1; end
          3'd2: begin emit.data = CMD_CUR_Y; emit.cmd = 1'b1; end
          3'd3: emit.data = row[7:0];
          3'd4: emit.data = {6'b0, row[9:8]};
          3'd5: begin emit.data = CMD_WRITE_RAM; emit.cmd = 1'b1; end
          default: emit.data = 8'h00;
        endcase
      end
      ST_DOUT: begin
        emit.valid = 1'b1;
        emit.data  = ram_rdata;
        emit.last  = (dcnt == DcLast) && !last_row;
      end
      ST_TRL: begin
        emit.valid = 1'b1;
        emit.cmd   = 1'b1;
        case (idx)
          3'd0: emit.data = CMD_UPD_CTRL;
          3'd1: begin emit.data = UPD_SEQ_FULL; emit.cmd = 1'b0; end
          3'd2: emit.data = CMD_ACTIVATE;
          default: begin emit.data = CMD_NOP; emit.last = 1'b1; end
        endcase
      end
      default: ;
    endcase
  end

  assign emit_take = emit.valid && emit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == ClrLast) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + AddrW'(1);
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            cur_i <= req.pixel_x;
            cur_j <= req.pixel_y;
            x0    <= req.pixel_x;
            color <= req.pixel_color;
            unique case (req.action)
              ACT_PLOT: begin
                xe    <= {1'b0, req.pixel_x} + 11'd1;
                ye    <= {1'b0, req.pixel_y} + 11'd1;
                state <= ST_PIX;
              end
              ACT_FILL: begin
                xe <= fill_xe;
                ye <= fill_ye;
                if (fill_ok) begin
                  state <= ST_PIX;
                end
              end
              ACT_LOAD: ;
              ACT_FLUSH: begin
                row      <= req.flush_row;
                row_base <= AddrW'(req.flush_row * RowBytes);
                last_row <= {1'b0, req.flush_row} == (HeightC - 11'd1);
                idx      <= 3'd0;
                if (row_ok) begin
                  state <= (req.flush_row == 10'd0) ? ST_HDR : ST_CUR;
                end
              end
            endcase
          end
        end
        ST_PIX: begin
          px <= rot_px;
          py <= rot_py;
          if (rot_ok) begin
            state <= ST_RD;
          end else begin
            if (step_i) begin
              cur_i <= cur_i + 10'd1;
            end else if (step_j) begin
              cur_i <= x0;
              cur_j <= cur_j + 10'd1;
            end
            state <= (step_i || step_j) ? ST_PIX : ST_IDLE;
          end
        end
        ST_RD: begin
          wr_addr <= pix_addr;
          state   <= ST_WR;
        end
        ST_WR: begin
          if (step_i) begin
            cur_i <= cur_i + 10'd1;
          end else if (step_j) begin
            cur_i <= x0;
            cur_j <= cur_j + 10'd1;
          end
          state <= (step_i || step_j) ? ST_PIX : ST_IDLE;
        end
        ST_HDR: begin
          if (emit_take) begin
            if (idx == 3'd7) begin
              idx   <= 3'd0;
              state <= ST_CUR;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        ST_CUR: begin
          if (emit_take) begin
            if (idx == 3'd5) begin
              dcnt  <= '0;
              state <= ST_DRD;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        ST_DRD: state <= ST_DOUT;
        ST_DOUT: begin
          if (emit_take) begin
            if (dcnt == DcLast) begin
              idx   <= 3'd0;
              state <= last_row ? ST_TRL : ST_IDLE;
            end else begin
              dcnt  <= dcnt + DcW'(1);
              state <= ST_DRD;
            end
          end
        end
        ST_TRL: begin
          if (emit_take) begin
            if (idx == 3'd3) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MFB_ASSERT(a_port_excl, ram_we |-> !ram_re, "store read and write in one cycle")
  `MFB_ASSERT(a_idle_quiet, req.ready |-> !emit.valid, "byte offered while idle")
  `MFB_ASSERT(a_clear_white, (state == ST_CLEAR) |-> (ram_we && ram_wdata == PIX_WHITE), "clearing pass not writing white")
  `MFB_ASSERT(a_rmw_pair, (state == ST_WR) |-> $past(ram_re), "write-back without preceding read")
  `MFB_ASSERT(a_last_ends, (emit_take && emit.last) |=> (state == ST_IDLE), "flush run continues past last byte")

endmodule

[rtl/mono_framebuffer_rotate_flush.sv]
// Top level of the rotating one-bit frame buffer with panel row flush.
//
// Channels: req carries requests (plot pixel, fill rectangle, load image
// byte, flush one row); res carries the panel byte stream, one byte per
// transfer with its command flag and a marker on the final byte of a flush.
// cfg_wr_en / cfg_wr_data write the rotation register.
//
// Reset: rotation returns to none and the frame store, DISPLAY_WIDTH/8
// (rounded up) times DISPLAY_HEIGHT bytes (2888 at 152 x 152), is swept to
// white, one byte per cycle. req.ready stays low during the sweep;
// configuration writes are taken throughout.
//
// Request handling, shaped by the one store port and its registered read:
//   plot on the panel:   accept, rotate, read, write back
//   plot dropped:        accept, rotate
//   fill:                accept, then rotate, read and write back per pixel
//                        on the panel, rotate only per dropped pixel
//   image load:          written at the accept edge
//   flush:               accept, fixed bytes, a read and a send per row byte
// A stalled receiver holds the output register; the sequencer waits on it.
// The next request is taken as soon as the last byte sits in that register.
module mono_framebuffer_rotate_flush #(
  parameter int DISPLAY_WIDTH  = mfb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = mfb_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  mfb_req_if.sink    req,
  mfb_res_if.source  res
);
  import mfb_pkg::*;

  localparam int RowBytes  = (DISPLAY_WIDTH + 7) / 8;
  localparam int StoreSize = RowBytes * DISPLAY_HEIGHT;
  localparam int AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;

  rot_t             rotation;
  emit_t            emit;
  logic             emit_ready;
  logic             out_valid;
  logic [7:0]       out_data;
  logic             out_cmd;
  logic             out_last;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  // Rotation register
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= ROT_0;
    end else if (cfg_wr_en) begin
      rotation <= rot_t'(cfg_wr_data);
    end
  end

  // Output register: free when empty or being taken
  assign emit_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid && emit_ready) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid && emit_ready) begin
      out_data <= emit.data;
      out_cmd  <= emit.cmd;
      out_last <= emit.last;
    end
  end

  assign res.valid      = out_valid;
  assign res.panel_byte = out_data;
  assign res.is_command = out_cmd;
  assign res.last_byte  = out_last;

  mfb_ctrl #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .rotation   (rotation),
    .req        (req),
    .emit       (emit),
    .emit_ready (emit_ready),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Frame store, rows padded to whole bytes, MSB is the leftmost pixel
  mfb_ram #(
    .WIDTH (8),
    .DEPTH (StoreSize)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[bench/tb_top.sv]
// Self-checking bench for the rotating one-bit frame buffer and its panel row flush.
`timescale 1ns / 100ps

module tb_top;
  import mfb_pkg::*;

  // Panel geometry, matching the defaults the block is built with
  localparam int PANEL_W     = DISPLAY_WIDTH_DEF;
  localparam int PANEL_H     = DISPLAY_HEIGHT_DEF;
  localparam int ROW_BYTES   = (PANEL_W + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_H;

  // Covers the reset sweep and one whole-panel fill, the longest request; the rest are far shorter.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Quiet cycles after the final byte, to catch stray output.
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_REPORTS = 40;

  localparam bit IS_CMD  = 1'b1;
  localparam bit IS_DATA = 1'b0;

  // One drawing/load/flush request as presented on the req channel
  typedef struct packed {
    action_t     act;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [9:0]  w;
    logic [9:0]  h;
    logic        colour;
    logic [7:0]  img;
    logic [11:0] ofs;
    logic [9:0]  row;
  } draw_req_t;

  // One byte on the panel link
  typedef struct packed {
    logic [7:0] data;
    logic       cmd;
    logic       last;
  } panel_xfer_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  mfb_req_if req ();
  mfb_res_if res ();

  mono_framebuffer_rotate_flush #(
    .DISPLAY_WIDTH  (PANEL_W),
    .DISPLAY_HEIGHT (PANEL_H)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .res         (res)
  );

  // Shadow copy of the frame store and the rotation register
  logic [7:0]  shadow_frame [STORE_BYTES];
  rot_t        shadow_rot;
  int          last_row_touched;

  // Panel bytes still owed by the block, oldest first
  panel_xfer_t panel_expected [$];

  int          mismatch_count;
  int unsigned cycle_count;

  // Idling controls: calm switches the random gaps off on that side,
  // sink_hold_req asks the receiver for one long hold-off.
  bit          src_calm;
  bit          sink_calm;
  int          sink_hold_req;
  int          sink_stall;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d panel bytes outstanding", cycle_count,
               panel_expected.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Idle lengths: mostly short, now and then a long one
  // ---------------------------------------------------------------------
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic int src_gap();
    if (src_calm || $urandom_range(0, 1) == 0)
      return 0;
    return idle_length();
  endfunction

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Set or clear one pixel, after rotation; anything off the panel is dropped.
  function automatic void plot_pixel(int x, int y, logic colour);
    int         px;
    int         py;
    int         addr;
    logic [7:0] mask;
    if (x < 0 || y < 0 || x >= PANEL_W || y >= PANEL_H)
      return;
    case (shadow_rot)
      ROT_90: begin
        px = PANEL_W - 1 - y;
        py = x;
      end
      ROT_180: begin
        px = PANEL_W - 1 - x;
        py = PANEL_H - 1 - y;
      end
      ROT_270: begin
        px = y;
        py = PANEL_H - 1 - x;
      end
      default: begin
        px = x;
        py = y;
      end
    endcase
    if (px < 0 || py < 0 || px >= PANEL_W || py >= PANEL_H)
      return;
    addr = px / 8 + py * ROW_BYTES;
    if (addr >= STORE_BYTES)
      return;
    mask = PIX_MSB >> (px & 7);
    if (colour)
      shadow_frame[addr] = shadow_frame[addr] | mask;
    else
      shadow_frame[addr] = shadow_frame[addr] & ~mask;
    last_row_touched = py;
  endfunction

  function automatic void queue_byte(logic [7:0] data, bit cmd);
    panel_xfer_t b;
    b.data = data;
    b.cmd  = cmd;
    b.last = 1'b0;
    panel_expected.push_back(b);
  endfunction

  // Byte stream of one row flush; rows beyond the panel send nothing.
  function automatic void predict_flush(int row);
    panel_xfer_t tail;
    if (row >= PANEL_H)
      return;
    if (row == 0) begin
      // window header, first row only
      queue_byte(CMD_WIN_X, IS_CMD);
      queue_byte(8'h00, IS_DATA);
      queue_byte(8'(PANEL_W >> 3), IS_DATA);
      queue_byte(CMD_WIN_Y, IS_CMD);
      queue_byte(8'h00, IS_DATA);
      queue_byte(8'h00, IS_DATA);
      queue_byte(8'(PANEL_H), IS_DATA);
      queue_byte(8'(PANEL_H >> 8), IS_DATA);
    end
    queue_byte(CMD_CUR_X, IS_CMD);
    queue_byte(8'h00, IS_DATA);
    queue_byte(CMD_CUR_Y, IS_CMD);
    queue_byte(8'(row), IS_DATA);
    queue_byte(8'(row >> 8), IS_DATA);
    queue_byte(CMD_WRITE_RAM, IS_CMD);
    for (int k = 0; k < ROW_BYTES; k++)
      queue_byte(shadow_frame[row * ROW_BYTES + k], IS_DATA);
    if (row == PANEL_H - 1) begin
      // refresh trailer after the bottom row
      queue_byte(CMD_UPD_CTRL, IS_CMD);
      queue_byte(UPD_SEQ_FULL, IS_DATA);
      queue_byte(CMD_ACTIVATE, IS_CMD);
      queue_byte(CMD_NOP, IS_CMD);
    end
    tail = panel_expected.pop_back();
    tail.last = 1'b1;
    panel_expected.push_back(tail);
  endfunction

  function automatic void predict_request(draw_req_t r);
    int xe;
    int ye;
    case (r.act)
      ACT_PLOT: plot_pixel(int'(r.x), int'(r.y), r.colour);
      ACT_FILL: begin
        // clip to the panel edge; zero width or height walks nothing
        xe = int'(r.x) + int'(r.w);
        ye = int'(r.y) + int'(r.h);
        if (xe > PANEL_W)
          xe = PANEL_W;
        if (ye > PANEL_H)
          ye = PANEL_H;
        for (int j = int'(r.y); j < ye; j++)
          for (int i = int'(r.x); i < xe; i++)
            plot_pixel(i, j, r.colour);
      end
      ACT_LOAD: begin
        if (int'(r.ofs) < STORE_BYTES)
          shadow_frame[r.ofs] = r.img;
      end
      default: predict_flush(int'(r.row));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  always @(posedge clk) begin
    panel_xfer_t want;
    if (!rst && res.valid && res.ready) begin
      if (panel_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected panel byte %02h cmd=%0b last=%0b",
                                  res.panel_byte, res.is_command, res.last_byte));
      end else begin
        want = panel_expected.pop_front();
        if (res.panel_byte !== want.data)
          report_mismatch($sformatf("panel_byte %02h, want %02h", res.panel_byte, want.data));
        if (res.is_command !== want.cmd)
          report_mismatch($sformatf("is_command %0b, want %0b on byte %02h",
                                    res.is_command, want.cmd, want.data));
        if (res.last_byte !== want.last)
          report_mismatch($sformatf("last_byte %0b, want %0b on byte %02h",
                                    res.last_byte, want.last, want.data));
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      sink_stall = 0;
    end else if (sink_hold_req > 0) begin
      sink_stall = sink_hold_req - 1;
      sink_hold_req = 0;
      res.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      res.ready <= 1'b0;
    end else if (!sink_calm && $urandom_range(0, 99) < 25) begin
      sink_stall = idle_length() - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic draw_req_t req_of(action_t act, int x, int y, int w, int h,
                                       bit colour, int img, int ofs, int row);
    draw_req_t r;
    r.act    = act;
    r.x      = 10'(x);
    r.y      = 10'(y);
    r.w      = 10'(w);
    r.h      = 10'(h);
    r.colour = colour;
    r.img    = 8'(img);
    r.ofs    = 12'(ofs);
    r.row    = 10'(row);
    return r;
  endfunction

  // Offer one request, hold it until taken, then update the shadow state.
  // valid stays high on exit so back-to-back requests need no extra edge.
  task automatic send_req(input draw_req_t r);
    int gap;
    gap = src_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= r.act;
    req.pixel_x      <= r.x;
    req.pixel_y      <= r.y;
    req.rect_width   <= r.w;
    req.rect_height  <= r.h;
    req.pixel_color  <= r.colour;
    req.image_byte   <= r.img;
    req.image_offset <= r.ofs;
    req.flush_row    <= r.row;
    @(posedge clk);
    while (!req.ready)
      @(posedge clk);
    predict_request(r);
  endtask

  // Drop valid and wait for every owed byte to come out.
  task automatic await_drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (panel_expected.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_rotation(input rot_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_rot = v;
    @(posedge clk);
  endtask

  // Plots and fills leave no trace on res, so a flush is sent first: once
  // its last byte is taken the block is known to be idle.
  task automatic change_rotation(input rot_t v);
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, PANEL_H - 1)));
    await_drain();
    repeat (4) @(posedge clk);
    write_rotation(v);
  endtask

  // Mostly well-formed requests on the panel, with some flushes of the last
  // row touched; a minority lands off the panel or out of the store.
  function automatic draw_req_t random_request();
    draw_req_t r;
    int        pick;
    r = req_of(ACT_PLOT, $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1),
               $urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if ($urandom_range(0, 9) != 0) begin
        r.x = 10'($urandom_range(0, PANEL_W - 1));
        r.y = 10'($urandom_range(0, PANEL_H - 1));
      end
    end else if (pick < 50) begin
      r.act = ACT_FILL;
      if ($urandom_range(0, 9) != 0) begin
        r.x = 10'($urandom_range(0, PANEL_W - 1));
        r.y = 10'($urandom_range(0, PANEL_H - 1));
      end
      if ($urandom_range(0, 9) == 0) begin
        r.w = 10'($urandom_range(13, 40));
        r.h = 10'($urandom_range(13, 40));
      end else begin
        r.w = 10'($urandom_range(0, 12));
        r.h = 10'($urandom_range(0, 12));
      end
    end else if (pick < 65) begin
      r.act = ACT_LOAD;
      if ($urandom_range(0, 7) != 0)
        r.ofs = 12'($urandom_range(0, STORE_BYTES - 1));
    end else begin
      r.act = ACT_FLUSH;
      case ($urandom_range(0, 9))
        0:       r.row = 10'd0;
        1:       r.row = 10'(PANEL_H - 1);
        2, 3:    r.row = 10'(last_row_touched);
        4:       ;  // raw 10-bit row, mostly beyond the panel
        default: r.row = 10'($urandom_range(0, PANEL_H - 1));
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Edges of the panel and of every field, with rotation at none.
  task automatic test_directed_edges();
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0));          // header, all white
    send_req(req_of(ACT_PLOT, 0, 0, 0, 0, 0, 0, 0, 0));           // top left black
    send_req(req_of(ACT_PLOT, PANEL_W - 1, PANEL_H - 1, 0, 0, 0, 0, 0, 0));
    send_req(req_of(ACT_PLOT, PANEL_W, 0, 0, 0, 0, 0, 0, 0));     // one past the right edge
    send_req(req_of(ACT_PLOT, 0, PANEL_H, 0, 0, 0, 0, 0, 0));     // one past the bottom
    send_req(req_of(ACT_PLOT, 1023, 1023, 1023, 1023, 0, 255, 4095, 1023));
    send_req(req_of(ACT_PLOT, 7, 0, 0, 0, 0, 0, 0, 0));           // either side of a byte
    send_req(req_of(ACT_PLOT, 8, 0, 0, 0, 0, 0, 0, 0));
    send_req(req_of(ACT_PLOT, 0, 0, 0, 0, 1, 0, 0, 0));           // back to white
    send_req(req_of(ACT_FILL, 140, 2, 1023, 2, 0, 0, 0, 0));      // clipped at the right
    send_req(req_of(ACT_FILL, 10, 3, 0, 5, 0, 0, 0, 0));          // zero width
    send_req(req_of(ACT_FILL, 10, 3, 5, 0, 0, 0, 0, 0));          // zero height
    send_req(req_of(ACT_FILL, 3, 140, 1, 1023, 0, 0, 0, 0));      // clipped at the bottom
    send_req(req_of(ACT_LOAD, 0, 0, 0, 0, 0, 8'h5A, ROW_BYTES, 0));
    send_req(req_of(ACT_LOAD, 0, 0, 0, 0, 0, 8'hA5, STORE_BYTES - 1, 0));
    send_req(req_of(ACT_LOAD, 0, 0, 0, 0, 0, 8'h00, STORE_BYTES, 0));   // just outside
    send_req(req_of(ACT_LOAD, 0, 0, 0, 0, 0, 8'hFF, 4095, 0));
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0));
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, 1));
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, 2));
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, 3));
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, PANEL_H - 2));
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, PANEL_H - 1));    // with trailer
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, PANEL_H));        // silent
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, 1023));           // silent
    await_drain();
  endtask

  // Random drawing under one rotation; the opening stretch runs without gaps.
  task automatic test_random_drawing(input rot_t rot, input int count);
    change_rotation(rot);
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n == 8) begin
        src_calm  = 1'b0;
        sink_calm = 1'b0;
      end
      send_req(random_request());
    end
    await_drain();
  endtask

  // One whole-panel fill, the slowest request there is, then a few marks on it.
  task automatic test_full_panel_fill();
    change_rotation(ROT_180);
    send_req(req_of(ACT_FILL, 0, 0, PANEL_W, PANEL_H, 0, 0, 0, 0));
    send_req(req_of(ACT_PLOT, 0, 0, 0, 0, 1, 0, 0, 0));
    send_req(req_of(ACT_PLOT, PANEL_W - 1, 5, 0, 0, 1, 0, 0, 0));
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0));
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, PANEL_H - 6));
    send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0, PANEL_H - 1));
    await_drain();
  endtask

  // Receiver holds off for a long stretch while flushes keep coming, so the
  // output register fills and the block must refuse further requests.
  task automatic test_output_backpressure();
    src_calm = 1'b1;
    sink_hold_req = 300;
    for (int n = 0; n < 6; n++)
      send_req(req_of(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0,
                      (n == 0) ? 0 : $urandom_range(0, PANEL_H - 1)));
    src_calm = 1'b0;
    await_drain();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 2'd0;
    req.valid        = 1'b0;
    req.action       = ACT_PLOT;
    req.pixel_x      = 10'd0;
    req.pixel_y      = 10'd0;
    req.rect_width   = 10'd0;
    req.rect_height  = 10'd0;
    req.pixel_color  = 1'b0;
    req.image_byte   = 8'd0;
    req.image_offset = 12'd0;
    req.flush_row    = 10'd0;
    res.ready        = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    src_calm         = 1'b0;
    sink_calm        = 1'b0;
    sink_hold_req    = 0;
    last_row_touched = 0;
    shadow_rot       = ROT_0;
    for (int i = 0; i < STORE_BYTES; i++)
      shadow_frame[i] = PIX_WHITE;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // register is taken during the clearing sweep; requests wait for ready
    write_rotation(ROT_0);
    test_directed_edges();
    test_random_drawing(ROT_270, 22);
    test_random_drawing(ROT_90, 22);
    test_full_panel_fill();
    test_random_drawing(ROT_180, 22);
    test_output_backpressure();
    test_random_drawing(ROT_0, 22);

    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (panel_expected.size() != 0)
      report_mismatch($sformatf("%0d panel bytes never arrived", panel_expected.size()));

    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
